>>> sv/mipb_pkg.sv
// ============================================================================
// mipb_pkg
// Shared constants for the monochrome image to page byte packer.
// ============================================================================
`default_nettype none

package mipb_pkg;

    // Defaults for the top level parameters
    localparam int MIPB_MAX_COLUMNS = 128;
    localparam int MIPB_MAX_ROWS    = 64;

    // Field widths
    localparam int PIXEL_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 8;
    localparam int STORE_W    = 7;   // bits of rows 0..6 of a group
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_IMAGE_ROWS    = 1'b0;
    localparam logic REG_IMAGE_COLUMNS = 1'b1;

    // Display controller command bytes
    localparam logic [BYTE_W-1:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [BYTE_W-1:0] HIGH_COL_CMD  = 8'h10;
    localparam logic [BYTE_W-1:0] START_COLUMN  = 8'h00;
    localparam logic [BYTE_W-1:0] HI_NIBBLE     = 8'hF0;
    localparam logic [BYTE_W-1:0] LO_NIBBLE     = 8'h0F;

    // Value of a lit pixel
    localparam logic [PIXEL_W-1:0] PIXEL_LIT = 8'd1;

    // Emit phases of one pixel
    localparam logic [1:0] PH_PAGE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

endpackage

`default_nettype wire

>>> sv/mipb_ram.sv
// ============================================================================
// mipb_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module mipb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/mono_image_to_page_bytes.sv
// ============================================================================
// mono_image_to_page_bytes
// Packs a row-major monochrome pixel stream into vertical display page bytes.
// ============================================================================
// Pixels enter one per transfer in row-major order; a pixel is lit only when
// its value is exactly 1. Each group of eight rows forms a page: row k of the
// group becomes bit k of a column byte. Partial bytes for rows 0..6 live in a
// per-column RAM (one entry per column, registered read). On the last row of
// a group, or on the image's last row, each pixel produces its column's byte
// as a data transfer (tuser[0]=1, tlast=1); column 0 is first preceded by the
// three command bytes 0xB0+page, 0x10 and 0x00 (tuser[0]=0, tlast=0).
// tuser[1] flags the final data byte of the image.
// Rate: one pixel per clock unless the output stalls. A pixel passes the read
// stage (RAM read on acceptance), then retires from the modify/write stage; a
// column 0 pixel of an emitting row needs four output transfers and holds the
// input until all four are loaded. The read-modify-write loop on the column RAM
// closes through a one-entry forwarding register, covering the single-column
// case where consecutive pixels hit the same entry. The column RAM needs no
// clearing pass: row 0 of every group overwrites its entry. Configuration
// (image_rows at 0x0, image_columns at 0x4) must be written only while idle,
// unenforced by the block; out-of-range values saturate to 1..MAX_ROWS/MAX_COLUMNS.
// ============================================================================
`default_nettype none

module mono_image_to_page_bytes #(
    parameter int MAX_COLUMNS = mipb_pkg::MIPB_MAX_COLUMNS,
    parameter int MAX_ROWS    = mipb_pkg::MIPB_MAX_ROWS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mipb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [mipb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [mipb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    // pixel input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mipb_pkg::PIXEL_W-1:0]       s_tdata,  // [7:0] pixel
    // byte output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [mipb_pkg::BYTE_W-1:0]        m_tdata,  // [7:0] out_byte
    output logic                                    m_tlast,  // run_last
    output logic      [1:0]                         m_tuser   // [0] is_data, [1] image_done
);

    import mipb_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = $clog2(MAX_ROWS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_CFG_W'(MIPB_MAX_ROWS);
            cols_cfg_reg <= COLS_CFG_W'(MIPB_MAX_COLUMNS);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_ROWS:    rows_cfg_reg <= pwdata[ROWS_CFG_W-1:0];
                REG_IMAGE_COLUMNS: cols_cfg_reg <= pwdata[COLS_CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_ROWS:    prdata = CFG_DATA_W'(rows_cfg_reg);
            REG_IMAGE_COLUMNS: prdata = CFG_DATA_W'(cols_cfg_reg);
            default:           prdata = '0;
        endcase
    end

    // Saturated limits
    logic [ROWS_CFG_W-1:0] rows_lim;
    logic [COLS_CFG_W-1:0] cols_lim;

    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_lim = ROWS_CFG_W'(1);
        end else if (rows_cfg_reg > ROWS_CFG_W'(MAX_ROWS)) begin
            rows_lim = ROWS_CFG_W'(MAX_ROWS);
        end else begin
            rows_lim = rows_cfg_reg;
        end
        if (cols_cfg_reg == '0) begin
            cols_lim = COLS_CFG_W'(1);
        end else if (COLS_CFG_W'(MAX_COLUMNS) < cols_cfg_reg) begin
            cols_lim = COLS_CFG_W'(MAX_COLUMNS);
        end else begin
            cols_lim = cols_cfg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: position counters, RAM read on acceptance
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             s_acc;
    logic             last_col, last_row, emit;
    logic [2:0]       sub;

    assign s_acc    = s_tvalid && s_tready;
    assign sub      = row_reg[2:0];
    // at or past the last position counts as the last position
    assign last_col = ((COLS_CFG_W+1)'(col_reg) + 1'b1) >= (COLS_CFG_W+1)'(cols_lim);
    assign last_row = ((ROWS_CFG_W+1)'(row_reg) + 1'b1) >= (ROWS_CFG_W+1)'(rows_lim);
    assign emit     = (sub == 3'd7) || last_row;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_acc) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Modify/write stage
    // ------------------------------------------------------------------
    logic             s2_vld_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [2:0]       s2_sub_reg;
    logic             s2_lit_reg;
    logic             s2_emit_reg;
    logic             s2_done_reg;
    logic [2:0]       s2_page_reg;
    logic [1:0]       phase_reg;

    logic             out_free, out_load, s2_retire;
    logic [STORE_W-1:0] ram_rd, base;
    logic [BYTE_W-1:0]  entry;
    logic               ram_we;

    // forwarding register: last entry written
    logic               fwd_vld_reg;
    logic [COL_W-1:0]   fwd_addr_reg;
    logic [STORE_W-1:0] fwd_data_reg;

    assign out_free  = !m_tvalid || m_tready;
    assign out_load  = s2_vld_reg && s2_emit_reg && out_free;
    assign s2_retire = s2_vld_reg &&
                       (!s2_emit_reg || (out_free && phase_reg == PH_DATA));
    assign s_tready  = !s2_vld_reg || s2_retire;

    always_comb begin
        if (s2_sub_reg == 3'd0) begin
            base = '0;           // group start overwrites the entry
        end else if (fwd_vld_reg && fwd_addr_reg == s2_col_reg) begin
            base = fwd_data_reg;
        end else begin
            base = ram_rd;
        end
        entry = BYTE_W'(base) | (BYTE_W'(s2_lit_reg) << s2_sub_reg);
    end

    assign ram_we = s2_retire && (s2_sub_reg != 3'd7);

    mipb_ram #(
        .WIDTH  (STORE_W),
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (COL_W)
    ) u_column_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s2_col_reg),
        .wr_data (entry[STORE_W-1:0]),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_addr_reg <= s2_col_reg;
            fwd_data_reg <= entry[STORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
            phase_reg  <= PH_DATA;
        end else if (s_acc) begin
            s2_vld_reg <= 1'b1;
            phase_reg  <= (col_reg == '0) ? PH_PAGE : PH_DATA;
        end else if (s2_retire) begin
            s2_vld_reg <= 1'b0;
        end else if (out_load && phase_reg != PH_DATA) begin
            phase_reg  <= phase_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s2_col_reg  <= col_reg;
            s2_sub_reg  <= sub;
            s2_lit_reg  <= (s_tdata == PIXEL_LIT);
            s2_emit_reg <= emit;
            s2_done_reg <= last_row && last_col;
            s2_page_reg <= 3'(row_reg >> 3);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] out_byte;
    logic              out_is_data;

    always_comb begin
        out_is_data = 1'b0;
        unique case (phase_reg)
            PH_PAGE: out_byte = PAGE_CMD_BASE + BYTE_W'(s2_page_reg);
            PH_HIGH: out_byte = ((START_COLUMN & HI_NIBBLE) >> 4) | HIGH_COL_CMD;
            PH_LOW:  out_byte = START_COLUMN & LO_NIBBLE;
            PH_DATA: begin
                out_byte    = entry;
                out_is_data = 1'b1;
            end
            default: out_byte = entry;
        endcase
    end

    logic              m_vld_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_data_reg;
    logic              m_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_load) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg <= out_byte;
            m_data_reg <= out_is_data;
            m_done_reg <= out_is_data && s2_done_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_data_reg;       // data byte is the last of its pixel
    assign m_tuser  = {m_done_reg, m_data_reg};

`ifndef SYNTHESIS
    // image_done only ever rides on a data byte
    a_done_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("image_done on a command byte");

    // command bytes advance one phase per output load
    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !s_acc && phase_reg != PH_DATA |=>
            phase_reg == $past(phase_reg) + 2'd1)
        else $error("command phase skipped");

    // the write stage never drops an item that still owes output
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg && s2_emit_reg && !out_free |=> s2_vld_reg &&
            $stable(s2_col_reg) && $stable(phase_reg))
        else $error("pending item lost under back-pressure");

    // column counter stays within the store
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (COLS_CFG_W+1)'(col_reg) < (COLS_CFG_W+1)'(MAX_COLUMNS))
        else $error("column index beyond store");
`endif

endmodule

`default_nettype wire
